>>> hw/rtl/lmf_pkg.sv
// Shared types and constants for the LED matrix pixel frame buffer.
// No dependencies; lmf_if, lmf_div and the top level import this package.
`timescale 1ns / 1ps

package lmf_pkg;

  // Store geometry.
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_MODULES = 8;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_MODULES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths of the request and response channels.
  localparam int MODE_W  = 2;
  localparam int COORD_W = 16;
  localparam int CIDX_W  = 7;
  localparam int BYTE_W  = 8;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODULES_ACROSS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODULES_DOWN   = 3'd6;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COLUMN = 2'd3;

  // Shared divider operand and result widths.
  localparam int DIV_W = 7;
  localparam int DSR_W = 5;

  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } lmf_div_req_t;

  typedef struct packed {
    logic [DIV_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } lmf_div_rsp_t;

endpackage

>>> hw/rtl/lmf_if.sv
// Valid/ready channel interfaces for pixel requests and their responses.
// Depends on lmf_pkg for field widths.
`timescale 1ns / 1ps

interface lmf_req_if import lmf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic                      color;
  logic [CIDX_W-1:0]         column_index;

  modport source (output valid, mode, x_coord, y_coord, color, column_index, input ready);
  modport sink   (input valid, mode, x_coord, y_coord, color, column_index, output ready);
endinterface

interface lmf_rsp_if import lmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              pixel_value;
  logic [BYTE_W-1:0] column_byte;
  logic              in_canvas;

  modport source (output valid, pixel_value, column_byte, in_canvas, input ready);
  modport sink   (input valid, pixel_value, column_byte, in_canvas, output ready);
endinterface

>>> hw/rtl/lmf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/lmf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lmf_pkg for the request and result structs.
`timescale 1ns / 1ps

module lmf_div import lmf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  lmf_div_req_t req,
  output logic         done,
  output lmf_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] shreg;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;

  logic [DSR_W:0]   rem_sh;
  logic [DSR_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh = {rem, shreg[DIV_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = (rem_sh >= {1'b0, dsr});
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Done pulses for one cycle after the last step.
      done <= !start && busy && (cnt == CNT_W'(DIV_W - 1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= req.dividend;
        dsr   <= req.divisor;
        rem   <= '0;
      end else if (busy) begin
        shreg <= {shreg[DIV_W-2:0], ge};
        rem   <= ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.quotient  = shreg;
  assign rsp.remainder = rem;

endmodule

>>> hw/rtl/led_matrix_pixel_framebuffer.sv
// Top level of the LED matrix pixel frame buffer: sequencer, coordinate path and store.
// Depends on lmf_pkg, lmf_if, lmf_ram and lmf_div.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    mode, x_coord, y_coord, color, column_index
//   rsp      out  valid/ready    pixel_value, column_byte, in_canvas
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// A column read passes from acceptance through S_READ and S_USE to S_DONE, which loads the response register.
// A pixel draw or read makes two passes of the shared 7-step divider, X then Y;
// a pixel clipped off the canvas goes from S_XFORM straight to S_DONE.
// A fill writes N store bytes in S_FILL, N being the bytes of the configured modules.
// Reset is synchronous; the store reads as zero through per-byte valid bits.
// A new request is taken once the previous response sits in the output register.
`timescale 1ns / 1ps

module led_matrix_pixel_framebuffer import lmf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lmf_req_if.sink               req,
  lmf_rsp_if.source             rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIM, S_FILLN, S_FILL, S_XFORM, S_DIVX, S_DIVY,
    S_MOD, S_IDX, S_READ, S_USE, S_DONE
  } state_t;

  localparam int SW = COORD_W + 2;

  // Saturate a 4-bit count into 1..8.
  function automatic logic [3:0] clamp8(input logic [3:0] v);
    logic [3:0] r;
    if (v == 4'd0) r = 4'd1;
    else if (v > 4'd8) r = 4'd8;
    else r = v;
    return r;
  endfunction

  // Configuration registers.
  logic [1:0] rotation;
  logic       mirror_x;
  logic       mirror_y;
  logic [4:0] column_count;
  logic [3:0] row_count;
  logic [3:0] modules_across;
  logic [3:0] modules_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation       <= 2'd0;
      mirror_x       <= 1'b0;
      mirror_y       <= 1'b0;
      column_count   <= 5'd8;
      row_count      <= 4'd8;
      modules_across <= 4'd1;
      modules_down   <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION:       rotation       <= cfg_data[1:0];
        REG_MIRROR_X:       mirror_x       <= cfg_data[0];
        REG_MIRROR_Y:       mirror_y       <= cfg_data[0];
        REG_COLUMN_COUNT:   column_count   <= cfg_data[4:0];
        REG_ROW_COUNT:      row_count      <= cfg_data[3:0];
        REG_MODULES_ACROSS: modules_across <= cfg_data[3:0];
        REG_MODULES_DOWN:   modules_down   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Saturated geometry.
  logic [4:0] cols_c;
  logic [3:0] rows_c;
  logic [3:0] across_c;
  logic [3:0] down_c;

  always_comb begin
    if (column_count == 5'd0) cols_c = 5'd1;
    else if (column_count > 5'(MAX_COLUMNS)) cols_c = 5'(MAX_COLUMNS);
    else cols_c = column_count;
    rows_c   = clamp8(row_count);
    across_c = clamp8(modules_across);
    down_c   = clamp8(modules_down);
  end

  // Sequencer registers.
  state_t            state;
  logic [MODE_W-1:0] mode_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic              color_r;
  logic [6:0]        w_r;
  logic [7:0]        h_r;
  logic [7:0]        ca_r;
  logic [ADDR_W:0]   fill_n;
  logic [ADDR_W:0]   fill_cnt;
  logic [6:0]        uy_r;
  logic [2:0]        qx_r;
  logic [2:0]        bit_r;
  logic [2:0]        qy_r;
  logic [3:0]        ry_r;
  logic [6:0]        module_r;
  logic [ADDR_W-1:0] addr;
  logic              rvalid;
  logic              res_pix;
  logic [BYTE_W-1:0] res_byte;
  logic              res_inside;
  logic              out_valid;
  logic              out_pix;
  logic [BYTE_W-1:0] out_byte;
  logic              out_inside;

  // Store, its valid bits and the shared divider.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [STORE_DEPTH-1:0] valid_bits;
  logic               div_start;
  lmf_div_req_t       div_req;
  logic               div_done;
  lmf_div_rsp_t       div_rsp;

  lmf_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  lmf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .rsp   (div_rsp)
  );

  // Rotation, clip and mirror on the signed coordinates.
  logic signed [SW-1:0] xs, ys, w_s, h_s, rw_s, rh_s;
  logic signed [SW-1:0] xr, yr, xt, yt, xm, ym;
  logic                 on_canvas;

  always_comb begin
    xs   = SW'(x_r);
    ys   = SW'(y_r);
    w_s  = SW'({1'b0, w_r});
    h_s  = SW'({1'b0, h_r});
    rw_s = rotation[0] ? h_s : w_s;
    rh_s = rotation[0] ? w_s : h_s;
    xr   = rotation[1] ? (rw_s - SW'(1) - xs) : xs;
    yr   = (rotation == 2'd1 || rotation == 2'd2) ? (rh_s - SW'(1) - ys) : ys;
    xt   = rotation[0] ? yr : xr;
    yt   = rotation[0] ? xr : yr;
    on_canvas = !xt[SW-1] && (xt < w_s) && !yt[SW-1] && (yt < h_s);
    xm   = mirror_x ? (w_s - SW'(1) - xt) : xt;
    ym   = mirror_y ? (h_s - SW'(1) - yt) : yt;
  end

  // Divider requests: X by rows, then Y by columns.
  always_comb begin
    div_start = 1'b0;
    div_req.dividend = {1'b0, xm[5:0]};
    div_req.divisor  = {1'b0, rows_c};
    if (state == S_XFORM) begin
      div_start = on_canvas;
    end else if (state == S_DIVX) begin
      div_start        = div_done;
      div_req.dividend = uy_r;
      div_req.divisor  = cols_c;
    end
  end

  // Store write port: fill sweep or the modified byte of a draw.
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] bit_mask;

  always_comb begin
    cur_byte  = rvalid ? ram_rdata : '0;
    bit_mask  = BYTE_W'(8'h01 << bit_r);
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = color_r ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
    if (state == S_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = fill_cnt[ADDR_W-1:0];
      ram_wdata = color_r ? 8'hff : 8'h00;
    end else if (state == S_USE && mode_r == MODE_DRAW) begin
      ram_we = 1'b1;
    end
  end

  // Valid bits: a byte never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (ram_we) begin
      valid_bits[ram_waddr] <= 1'b1;
    end
  end

  // Sequencer, working registers and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      rvalid <= valid_bits[addr];
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode_r     <= req.mode;
            x_r        <= req.x_coord;
            y_r        <= req.y_coord;
            color_r    <= req.color;
            addr       <= req.column_index;
            res_pix    <= 1'b0;
            res_byte   <= '0;
            res_inside <= 1'b0;
            state      <= (req.mode == MODE_COLUMN) ? S_READ : S_DIM;
          end
        end
        S_DIM: begin
          w_r   <= 7'({3'b0, rows_c} * {3'b0, across_c});
          h_r   <= 8'({3'b0, cols_c} * {4'b0, down_c});
          ca_r  <= 8'({3'b0, cols_c} * {4'b0, across_c});
          state <= (mode_r == MODE_FILL) ? S_FILLN : S_XFORM;
        end
        S_FILLN: begin
          if (({3'b0, ca_r} * {7'b0, down_c}) > 11'(STORE_DEPTH)) begin
            fill_n <= (ADDR_W+1)'(STORE_DEPTH);
          end else begin
            fill_n <= (ADDR_W+1)'({3'b0, ca_r} * {7'b0, down_c});
          end
          fill_cnt <= '0;
          state    <= S_FILL;
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt + 1'b1 == fill_n) begin
            state <= S_DONE;
          end
        end
        S_XFORM: begin
          uy_r <= ym[6:0];
          if (on_canvas) state <= S_DIVX;
          else state <= S_DONE;
        end
        S_DIVX: begin
          if (div_done) begin
            qx_r  <= div_rsp.quotient[2:0];
            bit_r <= div_rsp.remainder[2:0];
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            qy_r  <= div_rsp.quotient[2:0];
            ry_r  <= div_rsp.remainder[3:0];
            state <= S_MOD;
          end
        end
        S_MOD: begin
          module_r <= {4'b0, qx_r} + 7'({3'b0, across_c} * {4'b0, qy_r});
          state    <= S_IDX;
        end
        S_IDX: begin
          if (module_r >= 7'(MAX_MODULES)) begin
            state <= S_DONE;
          end else begin
            addr  <= ADDR_W'({3'b0, ry_r} + ({4'b0, module_r[2:0]} * {2'b0, cols_c}));
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_USE;
        end
        S_USE: begin
          if (mode_r == MODE_COLUMN) begin
            res_byte <= cur_byte;
          end else begin
            res_inside <= 1'b1;
            if (mode_r == MODE_READ) res_pix <= cur_byte[bit_r];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_pix    <= res_pix;
            out_byte   <= res_byte;
            out_inside <= res_inside;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE) && !rst;
  assign rsp.valid       = out_valid;
  assign rsp.pixel_value = out_pix;
  assign rsp.column_byte = out_byte;
  assign rsp.in_canvas   = out_inside;

`ifndef ASSERT_OFF
  // An accepted request always starts work.
  ast_accept_starts: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("accepted request did not leave idle");

  // The fill sweep stays inside its extent.
  ast_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> (fill_cnt < fill_n) && (fill_n <= (ADDR_W+1)'(STORE_DEPTH)))
    else $error("fill sweep beyond its extent");

  // The store is written only by a fill or a draw.
  ast_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_FILL || (state == S_USE && mode_r == MODE_DRAW))
    else $error("store written outside fill or draw");

  // Finishing a request loads the response register.
  ast_response_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!out_valid || rsp.ready) |=> out_valid && state == S_IDLE)
    else $error("response not loaded on completion");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for the LED matrix pixel frame buffer: directed and random requests.
// Depends on lmf_pkg, the lmf_req_if/lmf_rsp_if interfaces and led_matrix_pixel_framebuffer.
`timescale 1ns / 1ps

module tb;
  import lmf_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 160;
  localparam int MAX_ROWS     = 8;
  localparam int MAX_SPAN     = 8;
  localparam int PHASES       = 8;

  typedef struct packed {
    logic              pixel_value;
    logic [BYTE_W-1:0] column_byte;
    logic              in_canvas;
  } frame_rsp_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lmf_req_if req_ch ();
  lmf_rsp_if rsp_ch ();

  led_matrix_pixel_framebuffer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow copy of the configuration registers, kept at their register widths.
  logic [1:0]        shadow_rotation;
  logic              shadow_mirror_x;
  logic              shadow_mirror_y;
  logic [4:0]        shadow_columns;
  logic [3:0]        shadow_rows;
  logic [3:0]        shadow_across;
  logic [3:0]        shadow_down;
  logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];

  frame_rsp_t pending_rsp [$];
  int         send_gap_pct;
  int         recv_stall_pct;
  int         idle_cycles;
  bit         failed;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Saturate a module size register into 1..hi.
  function automatic int clamp_size(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Turn, clip, mirror and map a pixel to a store byte and bit; 0 when off canvas.
  function automatic bit locate_pixel(input int x_in, input int y_in,
                                      output int idx, output int bit_pos);
    int cols, rows, across, down, w, h, rw, rh, x, y, t, module_num;
    cols   = clamp_size(int'(shadow_columns), MAX_COLUMNS);
    rows   = clamp_size(int'(shadow_rows), MAX_ROWS);
    across = clamp_size(int'(shadow_across), MAX_SPAN);
    down   = clamp_size(int'(shadow_down), MAX_SPAN);
    w = rows * across;
    h = cols * down;
    rw = shadow_rotation[0] ? h : w;
    rh = shadow_rotation[0] ? w : h;
    x = x_in;
    y = y_in;
    idx = 0;
    bit_pos = 0;
    if (shadow_rotation[1]) x = rw - 1 - x;
    if (shadow_rotation == 2'd1 || shadow_rotation == 2'd2) y = rh - 1 - y;
    if (shadow_rotation[0]) begin
      t = x;
      x = y;
      y = t;
    end
    if (x < 0 || x >= w || y < 0 || y >= h) return 1'b0;
    if (shadow_mirror_x) x = w - x - 1;
    if (shadow_mirror_y) y = h - y - 1;
    module_num = x / rows + across * (y / cols);
    // Pixels on modules past the store bound are treated as off canvas.
    if (module_num >= MAX_MODULES) return 1'b0;
    idx = y % cols + module_num * cols;
    bit_pos = x % rows;
    return 1'b1;
  endfunction

  // Apply one accepted request to the shadow store and queue its expected response.
  task automatic model_request(input logic [MODE_W-1:0] mode,
                               input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic color, input logic [CIDX_W-1:0] cidx);
    frame_rsp_t exp_rsp;
    int idx, bit_pos, fill_len;
    exp_rsp = '0;
    case (mode)
      MODE_DRAW: begin
        if (locate_pixel(int'(x), int'(y), idx, bit_pos)) begin
          exp_rsp.in_canvas = 1'b1;
          shadow_store[idx][bit_pos] = color;
        end
      end
      MODE_READ: begin
        if (locate_pixel(int'(x), int'(y), idx, bit_pos)) begin
          exp_rsp.in_canvas = 1'b1;
          exp_rsp.pixel_value = shadow_store[idx][bit_pos];
        end
      end
      MODE_FILL: begin
        // Only the bytes of the configured modules are filled.
        fill_len = clamp_size(int'(shadow_columns), MAX_COLUMNS)
                   * clamp_size(int'(shadow_across), MAX_SPAN)
                   * clamp_size(int'(shadow_down), MAX_SPAN);
        if (fill_len > STORE_DEPTH) fill_len = STORE_DEPTH;
        for (int i = 0; i < fill_len; i++) shadow_store[i] = color ? 8'hff : 8'h00;
      end
      default: begin
        exp_rsp.column_byte = shadow_store[cidx];
      end
    endcase
    pending_rsp.push_back(exp_rsp);
  endtask

  // Send one request; entered and left at a falling edge.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic color, input logic [CIDX_W-1:0] cidx);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.mode         = mode;
    req_ch.x_coord      = x;
    req_ch.y_coord      = y;
    req_ch.color        = color;
    req_ch.column_index = cidx;
    do @(posedge clk); while (!req_ch.ready);
    model_request(mode, x, y, color, cidx);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected response has arrived.
  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one configuration register; entered and left at a falling edge.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      REG_ROTATION:       shadow_rotation = data[1:0];
      REG_MIRROR_X:       shadow_mirror_x = data[0];
      REG_MIRROR_Y:       shadow_mirror_y = data[0];
      REG_COLUMN_COUNT:   shadow_columns  = data[4:0];
      REG_ROW_COUNT:      shadow_rows     = data[3:0];
      REG_MODULES_ACROSS: shadow_across   = data[3:0];
      REG_MODULES_DOWN:   shadow_down     = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drain the block, then write the whole register set.
  task automatic configure(input int rot, input int mx, input int my, input int cols,
                           input int rows, input int across, input int down);
    wait_idle();
    write_register(REG_ROTATION, CFG_DATA_W'(rot));
    write_register(REG_MIRROR_X, CFG_DATA_W'(mx));
    write_register(REG_MIRROR_Y, CFG_DATA_W'(my));
    write_register(REG_COLUMN_COUNT, CFG_DATA_W'(cols));
    write_register(REG_ROW_COUNT, CFG_DATA_W'(rows));
    write_register(REG_MODULES_ACROSS, CFG_DATA_W'(across));
    write_register(REG_MODULES_DOWN, CFG_DATA_W'(down));
  endtask

  // The store reads as zero out of reset under the default geometry.
  task automatic test_power_on_state();
    send_request(MODE_READ, 0, 0, 1'b0, 0);
    send_request(MODE_COLUMN, 0, 0, 1'b0, 0);
    send_request(MODE_COLUMN, 0, 0, 1'b0, 127);
  endtask

  // Corner pixels, clear after set, and coordinates far off the canvas.
  task automatic test_pixel_corners();
    send_request(MODE_DRAW, 0, 0, 1'b1, 0);
    send_request(MODE_DRAW, 7, 7, 1'b1, 0);
    send_request(MODE_DRAW, 7, 0, 1'b1, 0);
    send_request(MODE_READ, 7, 7, 1'b0, 0);
    send_request(MODE_DRAW, 7, 7, 1'b0, 0);
    send_request(MODE_READ, 7, 7, 1'b0, 0);
    send_request(MODE_DRAW, -32768, 32767, 1'b1, 0);
    send_request(MODE_READ, 32767, -32768, 1'b0, 0);
    send_request(MODE_READ, 8, 0, 1'b0, 0);
    send_request(MODE_COLUMN, 0, 0, 1'b0, 0);
  endtask

  // Fill covers only the configured modules; later bytes keep their value.
  task automatic test_fill_and_scan();
    send_request(MODE_FILL, 0, 0, 1'b1, 0);
    send_request(MODE_COLUMN, 0, 0, 1'b0, 7);
    send_request(MODE_COLUMN, 0, 0, 1'b0, 8);
    send_request(MODE_FILL, 0, 0, 1'b0, 0);
  endtask

  // Out-of-range sizes saturate; a full grid maps some pixels past the module bound.
  task automatic test_register_limits();
    configure(3, 1, 1, 0, 0, 0, 0);
    send_request(MODE_DRAW, 0, 0, 1'b1, 0);
    send_request(MODE_READ, 0, 0, 1'b0, 0);
    send_request(MODE_READ, 1, 0, 1'b0, 0);
    configure(1, 0, 1, 31, 15, 15, 15);
    send_request(MODE_DRAW, 5, 60, 1'b1, 0);
    send_request(MODE_DRAW, 120, 10, 1'b1, 0);
    send_request(MODE_READ, 120, 10, 1'b0, 0);
    send_request(MODE_FILL, 0, 0, 1'b1, 0);
    send_request(MODE_COLUMN, 0, 0, 1'b0, 127);
  endtask

  // Random geometry per phase, mostly on-canvas pixels with read-back of the latest draw.
  task automatic test_random_traffic(input int total);
    int r, cols, rows, across, down, rw, rh;
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] x, y, last_x, last_y;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      send_gap_pct   = (phase < 3) ? 22 : (phase < 6) ? 65 : 0;
      recv_stall_pct = (phase < 3) ? 65 : (phase < 6) ? 22 : 0;
      r = $urandom_range(0, 9);
      cols = (r == 0) ? 0 : (r == 1) ? 16 : (r == 2) ? $urandom_range(17, 31)
                                                     : $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      rows = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      across = (r == 0) ? 0 : (r == 1) ? $urandom_range(8, 15) : $urandom_range(1, 3);
      r = $urandom_range(0, 9);
      down = (r == 0) ? 0 : (r == 1) ? $urandom_range(8, 15) : $urandom_range(1, 3);
      configure($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                cols, rows, across, down);
      rw = clamp_size(int'(shadow_rows), MAX_ROWS) * clamp_size(int'(shadow_across), MAX_SPAN);
      rh = clamp_size(int'(shadow_columns), MAX_COLUMNS)
           * clamp_size(int'(shadow_down), MAX_SPAN);
      if (shadow_rotation[0]) begin
        r = rw;
        rw = rh;
        rh = r;
      end
      last_x = 0;
      last_y = 0;
      for (int i = 0; i < total / PHASES; i++) begin
        r = $urandom_range(0, 99);
        mode = (r < 40) ? MODE_DRAW : (r < 75) ? MODE_READ : (r < 95) ? MODE_COLUMN
                                                                       : MODE_FILL;
        // Mostly just around the canvas, sometimes anywhere in the coordinate range.
        if ($urandom_range(0, 99) < 85) begin
          x = COORD_W'($urandom_range(0, rw + 1) - 1);
          y = COORD_W'($urandom_range(0, rh + 1) - 1);
        end else begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end
        if (mode == MODE_READ && $urandom_range(0, 1) == 1) begin
          x = last_x;
          y = last_y;
        end
        if (mode == MODE_DRAW) begin
          last_x = x;
          last_y = y;
        end
        send_request(mode, x, y, 1'($urandom), CIDX_W'($urandom));
      end
    end
  endtask

  // Response receiver with random back-pressure.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each accepted response with the oldest expected one.
  always @(posedge clk) begin : check_rsp
    frame_rsp_t exp_rsp;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response: pixel_value %0b column_byte %02h in_canvas %0b",
                 $time, rsp_ch.pixel_value, rsp_ch.column_byte, rsp_ch.in_canvas);
        failed = 1'b1;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_ch.pixel_value !== exp_rsp.pixel_value) begin
          $display("%0t: pixel_value expected %0b actual %0b",
                   $time, exp_rsp.pixel_value, rsp_ch.pixel_value);
          failed = 1'b1;
        end
        if (rsp_ch.column_byte !== exp_rsp.column_byte) begin
          $display("%0t: column_byte expected %02h actual %02h",
                   $time, exp_rsp.column_byte, rsp_ch.column_byte);
          failed = 1'b1;
        end
        if (rsp_ch.in_canvas !== exp_rsp.in_canvas) begin
          $display("%0t: in_canvas expected %0b actual %0b",
                   $time, exp_rsp.in_canvas, rsp_ch.in_canvas);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or a response.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("led_matrix_pixel_framebuffer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_DRAW;
    req_ch.x_coord      = '0;
    req_ch.y_coord      = '0;
    req_ch.color        = 1'b0;
    req_ch.column_index = '0;
    send_gap_pct        = 0;
    recv_stall_pct      = 0;
    shadow_rotation     = 2'd0;
    shadow_mirror_x     = 1'b0;
    shadow_mirror_y     = 1'b0;
    shadow_columns      = 5'd8;
    shadow_rows         = 4'd8;
    shadow_across       = 4'd1;
    shadow_down         = 4'd1;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    test_power_on_state();
    test_pixel_corners();
    test_fill_and_scan();
    test_register_limits();
    test_random_traffic(1600);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_rsp.size() == 0) begin
      $display("led_matrix_pixel_framebuffer regression: pass");
    end else begin
      $display("led_matrix_pixel_framebuffer regression: fail");
    end
    $finish;
  end

endmodule
